[src/ccs_pkg.sv]
// Shared types and constants for the chunked container scanner.
`default_nettype none
package ccs_pkg;

  // Scan phase of the chunk walker
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } ccs_phase_t;

  // What the payload words of the current chunk feed
  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_TEXTURE = 2'd1,
    KIND_SKIN    = 2'd2
  } ccs_kind_t;

  // Register index decoded from the APB address
  localparam logic REG_CONTAINER_LENGTH = 1'b0;
  localparam logic REG_MIN_BODY_LENGTH  = 1'b1;

  localparam logic [31:0] MIN_BODY_RESET = 32'd320;

  // Chunk tags, little-endian four-character codes
  localparam logic [31:0] TAG_BODY = 32'h3132_444D;
  localparam logic [31:0] TAG_TXID = 32'h4449_5854;
  localparam logic [31:0] TAG_SFID = 32'h4449_4653;
  localparam logic [31:0] TAG_TXAC = 32'h4341_5854;
  localparam logic [31:0] TAG_LDV1 = 32'h3156_444C;
  localparam logic [31:0] TAG_AFID = 32'h4449_4641;
  localparam logic [31:0] TAG_SKID = 32'h4449_4B53;
  localparam logic [31:0] TAG_PFID = 32'h4449_4650;
  localparam logic [31:0] TAG_BFID = 32'h4449_4642;

  // Skip flag bits
  localparam logic [7:0] FLAG_TXAC  = 8'h01;
  localparam logic [7:0] FLAG_LDV1  = 8'h02;
  localparam logic [7:0] FLAG_AFID  = 8'h04;
  localparam logic [7:0] FLAG_SKID  = 8'h08;
  localparam logic [7:0] FLAG_PFID  = 8'h10;
  localparam logic [7:0] FLAG_OTHER = 8'h80;

  typedef struct packed {
    logic [31:0] container_length;
    logic [15:0] min_body_length;
  } ccs_cfg_t;

  // One result as it leaves the scanner, before the body check
  typedef struct packed {
    logic        has_texture_id;
    logic [6:0]  texture_slot;
    logic [31:0] texture_id;
    logic        is_summary;
    logic [31:0] body_offset;
    logic [31:0] body_length;
    logic [7:0]  texture_count;
    logic [31:0] skin_first_id;
    logic [29:0] skin_count;
    logic [7:0]  skip_flags;
  } ccs_res_t;

  // Result as presented at the output ports
  typedef struct packed {
    ccs_res_t res;
    logic     body_found;
  } ccs_out_t;

endpackage
`default_nettype wire

[src/ccs_cfg.sv]
// APB register file for container length and minimum body length.
`default_nettype none
module ccs_cfg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  output ccs_pkg::ccs_cfg_t    cfg
);

  logic [31:0] len_r;
  logic [15:0] min_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg.container_length = len_r;
  assign cfg.min_body_length  = min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      min_r <= ccs_pkg::MIN_BODY_RESET[15:0];
    end else if (wr_en) begin
      case (paddr[2])
        ccs_pkg::REG_CONTAINER_LENGTH: len_r <= pwdata;
        ccs_pkg::REG_MIN_BODY_LENGTH:  min_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ccs_pkg::REG_CONTAINER_LENGTH: prdata = len_r;
      ccs_pkg::REG_MIN_BODY_LENGTH:  prdata = {16'd0, min_r};
      default:                       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/ccs_scan.sv]
// Per-byte chunk walker: header decode, payload word assembly, running totals.
`default_nettype none
module ccs_scan #(
  parameter int MAX_TEXTURE_IDS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         data_byte,
  input  wire ccs_pkg::ccs_cfg_t  cfg,
  output logic                    res_fire,
  output ccs_pkg::ccs_res_t       res
);

  localparam logic [29:0] MAX_IDS = 30'(MAX_TEXTURE_IDS);

  logic [31:0]         pos_r, pos_nxt;
  ccs_pkg::ccs_phase_t phase_r, phase_nxt;
  logic [63:0]         hdr_r, hdr_nxt;
  logic [31:0]         remain_r, remain_nxt;
  ccs_pkg::ccs_kind_t  kind_r, kind_nxt;
  logic [31:0]         word_r, word_nxt;
  logic [31:0]         widx_r, widx_nxt;
  logic [7:0]          wanted_r, wanted_nxt;
  logic [31:0]         body_off_r, body_off_nxt;
  logic [31:0]         body_len_r, body_len_nxt;
  logic [7:0]          tex_cnt_r, tex_cnt_nxt;
  logic [31:0]         skin_first_r, skin_first_nxt;
  logic [29:0]         skin_cnt_r, skin_cnt_nxt;
  logic [7:0]          flags_r, flags_nxt;

  logic        active, in_hdr, in_pay, take_hdr, overrun, word_done, last;
  logic [63:0] hdr_shift;
  logic [31:0] tag, size, asm_word, remain_dec, pos_inc;
  logic [32:0] start;
  logic [29:0] idx;
  logic [7:0]  n_words;
  logic        tex;
  logic [6:0]  slot;
  logic [31:0] tword;

  assign active     = pos_r < cfg.container_length;
  assign in_hdr     = phase_r == ccs_pkg::PH_HEADER;
  assign in_pay     = phase_r == ccs_pkg::PH_PAYLOAD;
  assign hdr_shift  = {data_byte, hdr_r[63:8]};
  assign tag        = hdr_shift[31:0];
  assign size       = hdr_shift[63:32];
  assign take_hdr   = active && in_hdr && (widx_r >= 32'd7);
  assign start      = {1'b0, pos_r} + 33'd1;
  assign overrun    = ({1'b0, start} + {2'b00, size}) > {2'b00, cfg.container_length};
  assign asm_word   = word_r | (32'(data_byte) << {widx_r[1:0], 3'b000});
  assign word_done  = widx_r[1:0] == 2'b11;
  assign idx        = widx_r[31:2];
  assign remain_dec = remain_r - 32'd1;
  assign pos_inc    = pos_r + 32'd1;
  assign last       = active && (pos_inc == cfg.container_length);
  assign n_words    = (size[31:2] > MAX_IDS) ? MAX_IDS[7:0] : size[9:2];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take_hdr) begin
      if (overrun) begin
        phase_nxt = ccs_pkg::PH_STOPPED;
      end else if (size == 32'd0) begin
        phase_nxt = ccs_pkg::PH_HEADER;
      end else begin
        phase_nxt = ccs_pkg::PH_PAYLOAD;
      end
    end else if (active && in_pay && (remain_dec == 32'd0)) begin
      phase_nxt = ccs_pkg::PH_HEADER;
    end
  end

  // Datapath and totals
  always_comb begin
    pos_nxt        = pos_r;
    hdr_nxt        = hdr_r;
    remain_nxt     = remain_r;
    kind_nxt       = kind_r;
    word_nxt       = word_r;
    widx_nxt       = widx_r;
    wanted_nxt     = wanted_r;
    body_off_nxt   = body_off_r;
    body_len_nxt   = body_len_r;
    tex_cnt_nxt    = tex_cnt_r;
    skin_first_nxt = skin_first_r;
    skin_cnt_nxt   = skin_cnt_r;
    flags_nxt      = flags_r;
    tex            = 1'b0;
    slot           = '0;
    tword          = '0;
    if (active) begin
      pos_nxt = pos_inc;
      if (in_hdr) begin
        hdr_nxt  = hdr_shift;
        widx_nxt = widx_r + 32'd1;
        if (take_hdr) begin
          widx_nxt = '0;
          word_nxt = '0;
          kind_nxt = ccs_pkg::KIND_OTHER;
          if (!overrun) begin
            if (tag == ccs_pkg::TAG_BODY) begin
              body_off_nxt = start[31:0];
              body_len_nxt = size;
            end else if (tag == ccs_pkg::TAG_TXID) begin
              tex_cnt_nxt = n_words;
              wanted_nxt  = n_words;
              kind_nxt    = ccs_pkg::KIND_TEXTURE;
            end else if (tag == ccs_pkg::TAG_SFID) begin
              skin_cnt_nxt = size[31:2];
              kind_nxt     = ccs_pkg::KIND_SKIN;
            end else if (tag == ccs_pkg::TAG_TXAC) begin
              flags_nxt = flags_r | ccs_pkg::FLAG_TXAC;
            end else if (tag == ccs_pkg::TAG_LDV1) begin
              flags_nxt = flags_r | ccs_pkg::FLAG_LDV1;
            end else if (tag == ccs_pkg::TAG_AFID) begin
              flags_nxt = flags_r | ccs_pkg::FLAG_AFID;
            end else if (tag == ccs_pkg::TAG_SKID) begin
              flags_nxt = flags_r | ccs_pkg::FLAG_SKID;
            end else if (tag == ccs_pkg::TAG_PFID || tag == ccs_pkg::TAG_BFID) begin
              flags_nxt = flags_r | ccs_pkg::FLAG_PFID;
            end else begin
              flags_nxt = flags_r | ccs_pkg::FLAG_OTHER;
            end
            if (size != 32'd0) begin
              remain_nxt = size;
            end
          end
        end
      end else if (in_pay) begin
        word_nxt = asm_word;
        if (word_done) begin
          if (kind_r == ccs_pkg::KIND_TEXTURE && idx < {22'd0, wanted_r}) begin
            tex   = 1'b1;
            slot  = idx[6:0];
            tword = asm_word;
          end else if (kind_r == ccs_pkg::KIND_SKIN && idx == 30'd0) begin
            skin_first_nxt = asm_word;
          end
          word_nxt = '0;
        end
        widx_nxt   = widx_r + 32'd1;
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          widx_nxt = '0;
          word_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= ccs_pkg::PH_HEADER;
      hdr_r        <= '0;
      remain_r     <= '0;
      kind_r       <= ccs_pkg::KIND_OTHER;
      word_r       <= '0;
      widx_r       <= '0;
      wanted_r     <= '0;
      body_off_r   <= '0;
      body_len_r   <= '0;
      tex_cnt_r    <= '0;
      skin_first_r <= '0;
      skin_cnt_r   <= '0;
      flags_r      <= '0;
    end else if (step) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      hdr_r        <= hdr_nxt;
      remain_r     <= remain_nxt;
      kind_r       <= kind_nxt;
      word_r       <= word_nxt;
      widx_r       <= widx_nxt;
      wanted_r     <= wanted_nxt;
      body_off_r   <= body_off_nxt;
      body_len_r   <= body_len_nxt;
      tex_cnt_r    <= tex_cnt_nxt;
      skin_first_r <= skin_first_nxt;
      skin_cnt_r   <= skin_cnt_nxt;
      flags_r      <= flags_nxt;
    end
  end

  assign res_fire = tex || last;

  always_comb begin
    res                = '0;
    res.has_texture_id = tex;
    res.texture_slot   = slot;
    res.texture_id     = tword;
    if (last) begin
      res.is_summary    = 1'b1;
      res.body_offset   = body_off_nxt;
      res.body_length   = body_len_nxt;
      res.texture_count = tex_cnt_nxt;
      res.skin_first_id = skin_first_nxt;
      res.skin_count    = skin_cnt_nxt;
      res.skip_flags    = flags_nxt;
    end
  end

endmodule
`default_nettype wire

[src/ccs_obuf.sv]
// Two-entry result pipe: staging register, body check, output register.
`default_nettype none
module ccs_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ccs_pkg::ccs_res_t  push_res,
  input  wire ccs_pkg::ccs_cfg_t  cfg,
  output logic                    up_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ccs_pkg::ccs_out_t       out_data
);

  logic              s1_valid_r;
  ccs_pkg::ccs_res_t s1_r;
  logic              o_valid_r;
  ccs_pkg::ccs_out_t o_r;
  logic              s1_move, found;
  logic [32:0]       body_end;

  // Stage 1 may move on when the output register is empty or draining
  assign s1_move  = !o_valid_r || !out_stall;
  assign up_stall = s1_valid_r && !s1_move;

  assign body_end = {1'b0, s1_r.body_offset} + {1'b0, s1_r.body_length};
  assign found    = s1_r.is_summary && (s1_r.body_offset != 32'd0) &&
                    (s1_r.body_length >= {16'd0, cfg.min_body_length}) &&
                    (body_end <= {1'b0, cfg.container_length});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        o_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_r <= push_res;
    end
    if (s1_move && s1_valid_r) begin
      o_r.res        <= s1_r;
      o_r.body_found <= found;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_r;

endmodule
`default_nettype wire

[src/chunked_container_scanner.sv]
// Top level of the chunked container scanner (tag-length-value chunk walk).
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------------------
//  in_       in         in_valid / in_stall       in_data_byte
//  out_      out        out_valid / out_stall     texture word and end-of-container summary
//  APB       in/out     psel penable pwrite pready container_length (0x0), min_body_length (0x4)
//
// One byte is taken per cycle while in_stall is low; the scanner state updates in the same cycle.
// A request that yields a result passes one staging register, then the body-bounds
// check into the output register, before it reaches out_valid.
// Throughput is one byte per clock, held only by out_stall backing up both registers.
// Reset (rst_n low, synchronous) clears scan state and totals, and sets
// container_length to 0 and min_body_length to 320.
// Write registers only while no request is in flight.
`default_nettype none
module chunked_container_scanner #(
  parameter int MAX_TEXTURE_IDS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_texture_id,
  output logic [6:0]       out_texture_slot,
  output logic [31:0]      out_texture_id,
  output logic             out_is_summary,
  output logic             out_body_found,
  output logic [31:0]      out_body_offset,
  output logic [31:0]      out_body_length,
  output logic [7:0]       out_texture_count,
  output logic [31:0]      out_skin_first_id,
  output logic [29:0]      out_skin_count,
  output logic [7:0]       out_skip_flags
);

  ccs_pkg::ccs_cfg_t cfg;
  ccs_pkg::ccs_res_t scan_res;
  ccs_pkg::ccs_out_t out_data;
  logic              step, res_fire, up_stall;

  // Register file
  ccs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the walker on every accepted byte
  assign in_stall = up_stall;
  assign step     = in_valid && !up_stall;

  ccs_scan #(
    .MAX_TEXTURE_IDS (MAX_TEXTURE_IDS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .cfg       (cfg),
    .res_fire  (res_fire),
    .res       (scan_res)
  );

  // Hold results here while the consumer stalls
  ccs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_fire),
    .push_res  (scan_res),
    .cfg       (cfg),
    .up_stall  (up_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_has_texture_id = out_data.res.has_texture_id;
  assign out_texture_slot   = out_data.res.texture_slot;
  assign out_texture_id     = out_data.res.texture_id;
  assign out_is_summary     = out_data.res.is_summary;
  assign out_body_found     = out_data.body_found;
  assign out_body_offset    = out_data.res.body_offset;
  assign out_body_length    = out_data.res.body_length;
  assign out_texture_count  = out_data.res.texture_count;
  assign out_skin_first_id  = out_data.res.skin_first_id;
  assign out_skin_count     = out_data.res.skin_count;
  assign out_skip_flags     = out_data.res.skip_flags;

  // Every result carries a texture word, a summary, or both
  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_texture_id || out_is_summary))
    else $error("result with neither texture word nor summary");

  // Summary fields stay clear outside the final result
  a_summary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_summary) |->
      (!out_body_found && out_skip_flags == 8'd0 && out_texture_count == 8'd0))
    else $error("summary fields set on a non-summary result");

  // Texture fields stay clear when no word completes
  a_texture_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_texture_id) |->
      (out_texture_slot == 7'd0 && out_texture_id == 32'd0))
    else $error("texture fields set without a texture word");

endmodule
`default_nettype wire
